### rtl/core/tds_pkg.sv
// Shared types, constants and helpers for the tag-delimited span detector.
// No dependencies; used by tds_cfg_regs, tds_span_fsm and the top level.
package tds_pkg;

	localparam int MAX_TAG_BYTES_DEF = 16;
	localparam int POSITION_BITS_DEF = 32;

	localparam int TAG_BYTES   = 16;   // bytes a register pair can hold
	localparam int TAG_BITS    = 8 * TAG_BYTES;
	localparam int TAG_LEN_W   = 5;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int OUT_POS_W   = 32;
	localparam int OUT_DATA_W  = 104;
	localparam int MIN_START_LEN = 3;

	localparam logic [7:0] OPEN_BYTE = 8'h3C;   // '<'

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_A_LO = 3'd0,
		REG_START_A_HI = 3'd1,
		REG_START_B_LO = 3'd2,
		REG_START_B_HI = 3'd3,
		REG_END_A_LO   = 3'd4,
		REG_END_A_HI   = 3'd5,
		REG_END_B_LO   = 3'd6,
		REG_END_B_HI   = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CHOICE = 3'd1,
		PH_START  = 3'd2,
		PH_BODY   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] start_a;
		logic [TAG_BITS-1:0] start_b;
		logic [TAG_BITS-1:0] end_a;
		logic [TAG_BITS-1:0] end_b;
	} tag_set_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] byte_position;
		logic [OUT_POS_W-1:0] end_position;
		logic [OUT_POS_W-1:0] start_position;
		logic                 tag_choice;
		logic [2:0]           parse_state;
	} result_t;

	// Length of a NUL-terminated tag, limited to max_bytes.
	function automatic logic [TAG_LEN_W-1:0] tag_len(input logic [TAG_BITS-1:0] tag,
			input int max_bytes);
		logic [TAG_LEN_W-1:0] len;
		logic                 found;
		len   = TAG_LEN_W'(max_bytes);
		found = 1'b0;
		for (int k = 0; k < TAG_BYTES; k++) begin
			if (!found && k < max_bytes && tag[8*k +: 8] == 8'h00) begin
				len   = TAG_LEN_W'(k);
				found = 1'b1;
			end
		end
		return len;
	endfunction

endpackage

### rtl/core/tds_cfg_regs.sv
// APB-style register file holding the start and end tags.
// Depends on tds_pkg.
module tds_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tds_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [tds_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [tds_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output tds_pkg::tag_set_t                tags
);

	logic [tds_pkg::CFG_DATA_W-1:0] start_a_lo_q, start_a_hi_q, start_b_lo_q, start_b_hi_q;
	logic [tds_pkg::CFG_DATA_W-1:0] end_a_lo_q, end_a_hi_q, end_b_lo_q, end_b_hi_q;
	tds_pkg::cfg_reg_t              reg_idx;
	logic                           wr_en;

	assign reg_idx = tds_pkg::cfg_reg_t'(paddr[tds_pkg::CFG_ADDR_W-1 -: tds_pkg::CFG_IDX_W]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_a_lo_q <= '0;
			start_a_hi_q <= '0;
			start_b_lo_q <= '0;
			start_b_hi_q <= '0;
			end_a_lo_q   <= '0;
			end_a_hi_q   <= '0;
			end_b_lo_q   <= '0;
			end_b_hi_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				tds_pkg::REG_START_A_LO: start_a_lo_q <= pwdata;
				tds_pkg::REG_START_A_HI: start_a_hi_q <= pwdata;
				tds_pkg::REG_START_B_LO: start_b_lo_q <= pwdata;
				tds_pkg::REG_START_B_HI: start_b_hi_q <= pwdata;
				tds_pkg::REG_END_A_LO:   end_a_lo_q   <= pwdata;
				tds_pkg::REG_END_A_HI:   end_a_hi_q   <= pwdata;
				tds_pkg::REG_END_B_LO:   end_b_lo_q   <= pwdata;
				tds_pkg::REG_END_B_HI:   end_b_hi_q   <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tds_pkg::REG_START_A_LO: prdata = start_a_lo_q;
			tds_pkg::REG_START_A_HI: prdata = start_a_hi_q;
			tds_pkg::REG_START_B_LO: prdata = start_b_lo_q;
			tds_pkg::REG_START_B_HI: prdata = start_b_hi_q;
			tds_pkg::REG_END_A_LO:   prdata = end_a_lo_q;
			tds_pkg::REG_END_A_HI:   prdata = end_a_hi_q;
			tds_pkg::REG_END_B_LO:   prdata = end_b_lo_q;
			tds_pkg::REG_END_B_HI:   prdata = end_b_hi_q;
		endcase
	end

	// Byte 0 of each tag sits in the low bits of the low word.
	assign tags.start_a = {start_a_hi_q, start_a_lo_q};
	assign tags.start_b = {start_b_hi_q, start_b_lo_q};
	assign tags.end_a   = {end_a_hi_q, end_a_lo_q};
	assign tags.end_b   = {end_b_hi_q, end_b_lo_q};

endmodule

### rtl/core/tds_span_fsm.sv
// Parse state machine, end-tag window and position counter.
// Depends on tds_pkg; tag bytes come from tds_cfg_regs.
module tds_span_fsm #(
	parameter int MAX_TAG_BYTES = tds_pkg::MAX_TAG_BYTES_DEF,
	parameter int POSITION_BITS = tds_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_value,
	input  logic              clear,
	input  tds_pkg::tag_set_t tags,
	output tds_pkg::result_t  result
);

	localparam int IDX_W = $clog2(MAX_TAG_BYTES);
	localparam int LEN_W = $clog2(MAX_TAG_BYTES + 1);
	localparam logic [LEN_W-1:0] FILL_MAX = LEN_W'(MAX_TAG_BYTES);

	tds_pkg::phase_t          phase_q, phase_d;
	logic [IDX_W-1:0]         exp_q, exp_d;
	logic                     chosen_q, chosen_d;
	logic [7:0]               win_q [MAX_TAG_BYTES];
	logic [7:0]               win_d [MAX_TAG_BYTES];
	logic [7:0]               shifted [MAX_TAG_BYTES];
	logic [LEN_W-1:0]         fill_q, fill_d, fill_inc;
	logic [POSITION_BITS-1:0] open_q, open_d, close_q, close_d, count_q, count_inc;

	logic [7:0]       st_a [MAX_TAG_BYTES];
	logic [7:0]       st_b [MAX_TAG_BYTES];
	logic [7:0]       et_a [MAX_TAG_BYTES];
	logic [7:0]       et_b [MAX_TAG_BYTES];
	logic [LEN_W-1:0] len_sa, len_sb, len_ea, len_eb, len_s, len_e;
	logic [7:0]       exp_byte;
	logic             a_ok, b_ok, end_match;

	always_comb begin
		for (int k = 0; k < MAX_TAG_BYTES; k++) begin
			st_a[k] = tags.start_a[8*k +: 8];
			st_b[k] = tags.start_b[8*k +: 8];
			et_a[k] = tags.end_a[8*k +: 8];
			et_b[k] = tags.end_b[8*k +: 8];
		end
	end

	assign len_sa = LEN_W'(tds_pkg::tag_len(tags.start_a, MAX_TAG_BYTES));
	assign len_sb = LEN_W'(tds_pkg::tag_len(tags.start_b, MAX_TAG_BYTES));
	assign len_ea = LEN_W'(tds_pkg::tag_len(tags.end_a, MAX_TAG_BYTES));
	assign len_eb = LEN_W'(tds_pkg::tag_len(tags.end_b, MAX_TAG_BYTES));
	assign len_s  = chosen_q ? len_sb : len_sa;
	assign len_e  = chosen_q ? len_eb : len_ea;

	assign a_ok = (int'(len_sa) >= tds_pkg::MIN_START_LEN) && (byte_value == st_a[1]);
	assign b_ok = (int'(len_sb) >= tds_pkg::MIN_START_LEN) && (byte_value == st_b[1]);
	assign exp_byte = chosen_q ? st_b[exp_q] : st_a[exp_q];

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign fill_inc  = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;

	// Window after taking the current byte at the tail.
	always_comb begin
		for (int i = 0; i < MAX_TAG_BYTES - 1; i++) begin
			shifted[i] = win_q[i + 1];
		end
		shifted[MAX_TAG_BYTES-1] = byte_value;
	end

	// Compare the last len_e window bytes with the chosen end tag.
	always_comb begin
		end_match = (fill_inc >= len_e);
		for (int k = 0; k < MAX_TAG_BYTES; k++) begin
			if (k < int'(len_e)) begin
				if (shifted[IDX_W'(MAX_TAG_BYTES - int'(len_e) + k)] !=
						(chosen_q ? et_b[k] : et_a[k])) begin
					end_match = 1'b0;
				end
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		exp_d    = exp_q;
		chosen_d = chosen_q;
		win_d    = win_q;
		fill_d   = fill_q;
		open_d   = open_q;
		close_d  = close_q;
		if (clear) begin
			phase_d  = tds_pkg::PH_IDLE;
			exp_d    = '0;
			chosen_d = 1'b0;
			fill_d   = '0;
			open_d   = '0;
			close_d  = '0;
		end else begin
			unique case (phase_q)
				tds_pkg::PH_IDLE: begin
					if (byte_value == tds_pkg::OPEN_BYTE) begin
						phase_d = tds_pkg::PH_CHOICE;
						open_d  = count_q;
					end
				end
				tds_pkg::PH_CHOICE: begin
					if (!a_ok && !b_ok) begin
						phase_d = tds_pkg::PH_IDLE;
						open_d  = '0;
					end else begin
						chosen_d = b_ok;
						exp_d    = IDX_W'(2);
						phase_d  = tds_pkg::PH_START;
					end
				end
				tds_pkg::PH_START: begin
					if (byte_value != exp_byte) begin
						phase_d  = tds_pkg::PH_IDLE;
						exp_d    = '0;
						chosen_d = 1'b0;
						open_d   = '0;
					end else if (int'(exp_q) + 1 >= int'(len_s)) begin
						exp_d   = '0;
						fill_d  = '0;
						phase_d = tds_pkg::PH_BODY;
						for (int i = 0; i < MAX_TAG_BYTES; i++) begin
							win_d[i] = 8'h00;
						end
					end else begin
						exp_d = exp_q + 1'b1;
					end
				end
				tds_pkg::PH_BODY: begin
					win_d  = shifted;
					fill_d = fill_inc;
					if (end_match) begin
						close_d = count_inc;
						phase_d = tds_pkg::PH_DONE;
						fill_d  = '0;
						for (int i = 0; i < MAX_TAG_BYTES; i++) begin
							win_d[i] = 8'h00;
						end
					end
				end
				default: begin
					// complete: hold until clear
				end
			endcase
		end

		result.parse_state    = phase_d;
		result.tag_choice     = (phase_d >= tds_pkg::PH_START) ? chosen_d : 1'b0;
		result.start_position = (phase_d != tds_pkg::PH_IDLE) ?
			tds_pkg::OUT_POS_W'(open_d) : '0;
		result.end_position   = (phase_d == tds_pkg::PH_DONE) ?
			tds_pkg::OUT_POS_W'(close_d) : '0;
		result.byte_position  = clear ? '0 : tds_pkg::OUT_POS_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tds_pkg::PH_IDLE;
			exp_q    <= '0;
			chosen_q <= 1'b0;
			fill_q   <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			exp_q    <= exp_d;
			chosen_q <= chosen_d;
			fill_q   <= fill_d;
			count_q  <= clear ? '0 : count_inc;
		end
	end

	// Window bytes and span positions are only read once the phase makes them valid.
	always_ff @(posedge clk) begin
		if (step) begin
			win_q   <= win_d;
			open_q  <= open_d;
			close_q <= close_d;
		end
	end

endmodule

### rtl/core/tag_delimited_span_detector.sv
// A registered result item appears on the master side in the cycle after its input item is taken.
// One item per cycle unless the output stalls; state, window compare and counter update per item.
// The output register frees up in the same cycle it is taken, so no bubble under full flow.
// Reset clears the parse state, the position counter, all tag registers and the output valid.
// Depends on tds_pkg, tds_cfg_regs and tds_span_fsm.
module tag_delimited_span_detector #(
	parameter int MAX_TAG_BYTES = tds_pkg::MAX_TAG_BYTES_DEF,
	parameter int POSITION_BITS = tds_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // byte_value
	input  logic [0:0]                       s_tuser,   // clear
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// parse_state, tag_choice, start_position, end_position, byte_position, zero pad
	output logic [tds_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tds_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [tds_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [tds_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int PAD_W = tds_pkg::OUT_DATA_W - $bits(tds_pkg::result_t);

	tds_pkg::tag_set_t tags;
	tds_pkg::result_t  result;
	logic              step;
	logic              out_valid_q;
	tds_pkg::result_t  out_data_q;

	tds_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tags    (tags)
	);

	tds_span_fsm #(
		.MAX_TAG_BYTES (MAX_TAG_BYTES),
		.POSITION_BITS (POSITION_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_value (s_tdata),
		.clear      (s_tuser[0]),
		.tags       (tags),
		.result     (result)
	);

	// Take a new item whenever the output register is empty or drains this cycle.
	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_data_q};

endmodule

### dv/tds_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the tag-delimited span detector: follows the tag register writes,
// predicts the result of every byte taken and compares it with the result stream.
// Depends on tds_pkg.
module tds_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // byte_value
	input  logic [0:0]                     s_tuser,   // clear
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// parse_state, tag_choice, start_position, end_position, byte_position, zero pad
	input  logic [tds_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [tds_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tds_pkg::CFG_DATA_W-1:0] pwdata,
	output int                             errors,
	output int                             outstanding
);

	localparam int WIN = tds_pkg::MAX_TAG_BYTES_DEF;
	localparam int RES_W = $bits(tds_pkg::result_t);

	logic [63:0]       tag_reg [8];
	tds_pkg::phase_t   phase;
	logic [3:0]        want_idx;
	logic              chosen_b;
	logic [7:0]        win [WIN];
	int                fill;
	logic [31:0]       open_pos;
	logic [31:0]       close_pos;
	logic [31:0]       count;
	tds_pkg::result_t  span_results_due [$];
	int                fail_count = 0;
	int                due_count = 0;

	assign errors      = fail_count;
	assign outstanding = due_count;

	function automatic logic [127:0] tag_of(input int lo_idx);
		return {tag_reg[lo_idx + 1], tag_reg[lo_idx]};
	endfunction

	function automatic int len_of(input logic [127:0] tag);
		for (int k = 0; k < WIN; k++)
			if (tag[8*k +: 8] == 8'h00)
				return k;
		return WIN;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void empty_window();
		for (int k = 0; k < WIN; k++)
			win[k] = 8'h00;
		fill = 0;
	endfunction

	function automatic void clear_search();
		phase     = tds_pkg::PH_IDLE;
		want_idx  = '0;
		chosen_b  = 1'b0;
		open_pos  = '0;
		close_pos = '0;
		empty_window();
	endfunction

	// Advance the parser by one byte and return the result it reports.
	function automatic tds_pkg::result_t scan_byte(input logic [7:0] c, input logic clr);
		tds_pkg::result_t r;
		logic [127:0]     tag;
		logic [31:0]      pos;
		int               len;
		logic             a_ok;
		logic             b_ok;
		logic             hit;
		r = '0;
		if (clr) begin
			clear_search();
			count = '0;
			return r;
		end
		pos   = count;
		count = sat_inc(count);
		case (phase)
			tds_pkg::PH_IDLE: begin
				if (c == tds_pkg::OPEN_BYTE) begin
					phase    = tds_pkg::PH_CHOICE;
					open_pos = pos;
				end
			end
			tds_pkg::PH_CHOICE: begin
				tag  = tag_of(tds_pkg::REG_START_A_LO);
				a_ok = len_of(tag) >= tds_pkg::MIN_START_LEN && c == tag[15:8];
				tag  = tag_of(tds_pkg::REG_START_B_LO);
				b_ok = len_of(tag) >= tds_pkg::MIN_START_LEN && c == tag[15:8];
				// B wins when both tags fit
				if (!a_ok && !b_ok) begin
					clear_search();
				end else begin
					chosen_b = b_ok;
					want_idx = 4'd2;
					phase    = tds_pkg::PH_START;
				end
			end
			tds_pkg::PH_START: begin
				tag = tag_of(chosen_b ? tds_pkg::REG_START_B_LO : tds_pkg::REG_START_A_LO);
				len = len_of(tag);
				if (c != tag[8*want_idx +: 8]) begin
					clear_search();
				end else if (int'(want_idx) + 1 >= len) begin
					want_idx = '0;
					empty_window();
					phase = tds_pkg::PH_BODY;
				end else begin
					want_idx = want_idx + 4'd1;
				end
			end
			tds_pkg::PH_BODY: begin
				tag = tag_of(chosen_b ? tds_pkg::REG_END_B_LO : tds_pkg::REG_END_A_LO);
				len = len_of(tag);
				for (int k = 0; k < WIN - 1; k++)
					win[k] = win[k + 1];
				win[WIN - 1] = c;
				if (fill < WIN)
					fill++;
				// compare the newest len bytes with the end tag
				hit = fill >= len;
				for (int j = 0; j < len; j++)
					if (win[WIN - len + j] != tag[8*j +: 8])
						hit = 1'b0;
				if (hit) begin
					close_pos = sat_inc(pos);
					phase     = tds_pkg::PH_DONE;
					empty_window();
				end
			end
			default: ;
		endcase
		r.parse_state    = phase;
		r.tag_choice     = (phase >= tds_pkg::PH_START) ? chosen_b : 1'b0;
		r.start_position = (phase != tds_pkg::PH_IDLE) ? open_pos : '0;
		r.end_position   = (phase == tds_pkg::PH_DONE) ? close_pos : '0;
		r.byte_position  = pos;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			fail_count++;
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		tds_pkg::result_t want;
		tds_pkg::result_t seen;
		if (!arst_n) begin
			for (int k = 0; k < 8; k++)
				tag_reg[k] = '0;
			clear_search();
			count = '0;
			span_results_due.delete();
		end else begin
			// compare first: a result taken now belongs to an earlier byte
			if (m_tvalid && m_tready) begin
				seen = m_tdata[RES_W-1:0];
				if (span_results_due.size() == 0) begin
					fail_count++;
					$display("%0t result with nothing expected: actual %0h", $time, m_tdata);
				end else begin
					want = span_results_due.pop_front();
					check_field("parse_state", 32'(want.parse_state),
						32'(seen.parse_state));
					check_field("tag_choice", 32'(want.tag_choice), 32'(seen.tag_choice));
					check_field("start_position", want.start_position, seen.start_position);
					check_field("end_position", want.end_position, seen.end_position);
					check_field("byte_position", want.byte_position, seen.byte_position);
					check_field("pad", '0, 32'(m_tdata[tds_pkg::OUT_DATA_W-1:RES_W]));
				end
			end
			if (psel && penable && pwrite && pready)
				tag_reg[paddr[tds_pkg::CFG_ADDR_W-1:3]] = pwdata;
			if (s_tvalid && s_tready)
				span_results_due.push_back(scan_byte(s_tdata, s_tuser[0]));
		end
		due_count = span_results_due.size();
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Top of the span detector bench: clock, reset, tag register writes, byte stream and
// result-side backpressure; the verdict comes from tds_checker's failure count.
// Depends on tds_pkg, tds_checker and tag_delimited_span_detector.
module tb;

	localparam int STALL_LIMIT = 2000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [tds_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [tds_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [tds_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [tds_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;
	int                             fails;
	int                             due;
	int                             items_sent = 0;
	int                             idle_cycles = 0;
	logic                           src_steady = 1'b0;
	logic                           sink_steady = 1'b0;
	logic                           hold_sink = 1'b0;
	logic [127:0]                   start_a = '0;
	logic [127:0]                   start_b = '0;
	logic [127:0]                   end_a = '0;
	logic [127:0]                   end_b = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tag_delimited_span_detector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tds_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (fails),
		.outstanding (due)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic int tag_length(input logic [127:0] tag);
		for (int k = 0; k < 16; k++)
			if (tag[8*k +: 8] == 8'h00)
				return k;
		return 16;
	endfunction

	function automatic logic [127:0] pack_tag(input string s);
		logic [127:0] t;
		t = '0;
		for (int k = 0; k < s.len() && k < 16; k++)
			t[8*k +: 8] = s[k];
		return t;
	endfunction

	// Random tag of len bytes opening with '<'; bytes past the NUL may hold garbage.
	function automatic logic [127:0] make_tag(input int len);
		logic [127:0] t;
		t = {$urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 1))
			t = '0;
		for (int k = 0; k < 16; k++) begin
			if (k < len)
				t[8*k +: 8] = 8'($urandom_range(1, 255));
			else if (k == len)
				t[8*k +: 8] = 8'h00;
		end
		if (len > 0)
			t[7:0] = tds_pkg::OPEN_BYTE;
		return t;
	endfunction

	function automatic int tag_size(input bit opening);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return opening ? $urandom_range(0, 2) : 0;
		if (r < 30)
			return 16;
		return $urandom_range(opening ? 3 : 1, 6);
	endfunction

	function automatic logic [7:0] pick_byte(input logic [127:0] tag);
		int len;
		int k;
		len = tag_length(tag);
		if (len == 0 || $urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		k = $urandom_range(0, len - 1);
		return tag[8*k +: 8];
	endfunction

	task automatic write_reg(input tds_pkg::cfg_reg_t idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_tags(input logic [127:0] sa, input logic [127:0] sb,
			input logic [127:0] ea, input logic [127:0] eb);
		start_a = sa;
		start_b = sb;
		end_a   = ea;
		end_b   = eb;
		write_reg(tds_pkg::REG_START_A_LO, sa[63:0]);
		write_reg(tds_pkg::REG_START_A_HI, sa[127:64]);
		write_reg(tds_pkg::REG_START_B_LO, sb[63:0]);
		write_reg(tds_pkg::REG_START_B_HI, sb[127:64]);
		write_reg(tds_pkg::REG_END_A_LO, ea[63:0]);
		write_reg(tds_pkg::REG_END_A_HI, ea[127:64]);
		write_reg(tds_pkg::REG_END_B_LO, eb[63:0]);
		write_reg(tds_pkg::REG_END_B_HI, eb[127:64]);
	endtask

	task automatic send_item(input logic [7:0] b, input logic clr);
		int gap;
		gap = (hold_sink || src_steady || $urandom_range(0, 99) >= 30) ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= clr;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Drop valid and wait for every result to drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// One span with random content, broken now and then.
	task automatic send_span();
		logic [7:0]   text [$];
		logic [127:0] st;
		logic [127:0] et;
		logic         use_b;
		if ($urandom_range(0, 99) < 80)
			send_item(8'($urandom_range(0, 255)), 1'b1);
		repeat ($urandom_range(0, 3))
			text.push_back(($urandom_range(0, 3) == 0) ? tds_pkg::OPEN_BYTE :
				8'($urandom_range(0, 255)));
		use_b = 1'($urandom_range(0, 1));
		st    = use_b ? start_b : start_a;
		et    = use_b ? end_b : end_a;
		text.push_back(tds_pkg::OPEN_BYTE);
		for (int k = 1; k < tag_length(st); k++)
			text.push_back(st[8*k +: 8]);
		repeat ($urandom_range(0, 6))
			text.push_back(pick_byte(et));
		for (int k = 0; k < tag_length(et); k++)
			text.push_back(et[8*k +: 8]);
		repeat ($urandom_range(0, 2))
			text.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 99) < 20)
			text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		foreach (text[i])
			send_item(text[i], $urandom_range(0, 99) < 2);
	endtask

	initial begin : sink
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				// long hold-off so the block fills and stalls its input
				m_tready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_sink = 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (sink_steady || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall = gap_len() - 1;
			end
		end
	end

	initial begin : stimulus
		logic [127:0] sa;
		logic [127:0] sb;
		logic [127:0] ea;
		logic [127:0] eb;
		int           target;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset tags are empty: '<' never leads anywhere
		send_item(8'hFF, 1'b1);
		send_item(tds_pkg::OPEN_BYTE, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		settle();

		// both start tags share byte 1, so B wins; B's empty end tag closes at once
		load_tags(pack_tag("<pA>"), pack_tag("<pB>"), pack_tag("</pA>"), '0);
		send_item(8'h00, 1'b1);
		send_item(tds_pkg::OPEN_BYTE, 1'b0);
		send_item("p", 1'b0);
		send_item("B", 1'b0);
		send_item(">", 1'b0);
		send_item("z", 1'b0);
		send_item(tds_pkg::OPEN_BYTE, 1'b0);
		send_item(8'h00, 1'b1);
		settle();

		// too short a start tag, and full-width all-ones tags
		load_tags(pack_tag("<q"), '1, pack_tag("</q>"), '1);
		send_item(8'h5A, 1'b1);
		send_item(tds_pkg::OPEN_BYTE, 1'b0);
		send_item("q", 1'b0);
		send_item(tds_pkg::OPEN_BYTE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		settle();

		for (int p = 0; p < 6; p++) begin
			src_steady  = (p == 1);
			sink_steady = (p == 1 || p == 3);
			sa = make_tag((p == 0) ? 16 : tag_size(1'b1));
			sb = make_tag(tag_size(1'b1));
			ea = make_tag((p == 0) ? 16 : tag_size(1'b0));
			eb = make_tag(tag_size(1'b0));
			if (tag_length(sa) >= 2 && tag_length(sb) >= 2 && $urandom_range(0, 2) == 0)
				sb[15:8] = sa[15:8];
			load_tags(sa, sb, ea, eb);
			if (p == 2)
				hold_sink = 1'b1;
			target = items_sent + 100;
			while (items_sent < target)
				send_span();
			settle();
		end

		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/tds_pkg.sv
rtl/core/tds_cfg_regs.sv
rtl/core/tds_span_fsm.sv
rtl/core/tag_delimited_span_detector.sv
dv/tds_checker.sv
dv/tb.sv
